// ----- src/splitmix64_generator_macros.svh -----
// ----------------------------------------------------------------------------
// SplitMix64 generator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while rst_n low.
// ----------------------------------------------------------------------------
`ifndef SPLITMIX64_GENERATOR_MACROS_SVH
`define SPLITMIX64_GENERATOR_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/smx_pkg.sv -----
// ----------------------------------------------------------------------------
// smx_pkg
// Types and constants shared by the SplitMix64 generator modules.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam logic [63:0] SM_INCREMENT = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MULT_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MULT_B    = 64'h94d049bb133111eb;
    localparam int          SM_SHIFT_A   = 30;
    localparam int          SM_SHIFT_B   = 27;
    localparam int          SM_SHIFT_C   = 31;

    // restoring modulo: one dividend bit per step
    localparam int MOD_STEPS = 64;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // partial products of the 64x64 low-half multiply
    localparam logic [1:0] PH_LL  = 2'd0;
    localparam logic [1:0] PH_LH  = 2'd1;
    localparam logic [1:0] PH_HL  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    typedef struct packed {
        logic        action;
        logic [63:0] seed_value;
        logic [31:0] bound;
    } in_t;

    typedef struct packed {
        logic [63:0] raw_value;
        logic [31:0] bounded_value;
        logic        coin;
        logic [63:0] state_after;
    } out_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CAPTURE,
        OP_ADV,
        OP_MUL,
        OP_XSB,
        OP_FIN,
        OP_MOD,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       mul_b;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic act;
    } status_t;

endpackage

// ----- src/smx_dpath.sv -----
// ----------------------------------------------------------------------------
// smx_dpath
// Generator state, mixing datapath with one shared 32x32 multiplier,
// bit-serial modulo and the result register.
// ----------------------------------------------------------------------------
`include "splitmix64_generator_macros.svh"

module smx_dpath
    import smx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  in_t     in_data,
    output status_t status,
    output out_t    out_data
);

    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [63:0] v_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] seed_reg;
    logic [31:0] bound_reg;
    logic        act_reg;
    logic [63:0] raw_reg;
    logic [63:0] div_reg;
    logic [31:0] rem_reg;
    out_t        out_reg;

    logic [63:0] adv_sum;
    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] fin_val;
    logic [32:0] trial;
    logic [32:0] trial_sub;

    assign adv_sum   = state_reg + SM_INCREMENT;
    assign mul_const = cmd.mul_b ? SM_MULT_B : SM_MULT_A;
    assign fin_val   = v_reg ^ (v_reg >> SM_SHIFT_C);
    assign trial     = {rem_reg, div_reg[63]};
    assign trial_sub = trial - {1'b0, bound_reg};

    always_comb
    begin
        unique case (cmd.phase)
            PH_LL:
            begin
                mul_x = v_reg[31:0];
                mul_y = mul_const[31:0];
            end
            PH_LH:
            begin
                mul_x = v_reg[31:0];
                mul_y = mul_const[63:32];
            end
            PH_HL:
            begin
                mul_x = v_reg[63:32];
                mul_y = mul_const[31:0];
            end
            default:
            begin
                mul_x = v_reg[31:0];
                mul_y = mul_const[31:0];
            end
        endcase
    end

    assign mul_p = 64'(mul_x) * 64'(mul_y);

    always_comb
    begin
        state_next = state_reg;
        if (cmd.op == OP_ADV)
        begin
            state_next = adv_sum;
        end
        else if (cmd.op == OP_EMIT && act_reg)
        begin
            state_next = seed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                act_reg   <= in_data.action;
                seed_reg  <= in_data.seed_value;
                bound_reg <= in_data.bound;
            end
            OP_ADV:
            begin
                v_reg <= adv_sum ^ (adv_sum >> SM_SHIFT_A);
            end
            OP_MUL:
            begin
                unique case (cmd.phase)
                    PH_LL:
                    begin
                        prod_reg <= mul_p;
                    end
                    PH_LH:
                    begin
                        acc_reg  <= prod_reg;
                        prod_reg <= mul_p;
                    end
                    PH_HL:
                    begin
                        acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                        prod_reg       <= mul_p;
                    end
                    default:
                    begin
                        v_reg <= {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                    end
                endcase
            end
            OP_XSB:
            begin
                v_reg <= v_reg ^ (v_reg >> SM_SHIFT_B);
            end
            OP_FIN:
            begin
                raw_reg <= fin_val;
                div_reg <= fin_val;
                rem_reg <= '0;
            end
            OP_MOD:
            begin
                // restore when the trial remainder falls below the bound
                if (trial >= {1'b0, bound_reg})
                begin
                    rem_reg <= trial_sub[31:0];
                end
                else
                begin
                    rem_reg <= trial[31:0];
                end
                div_reg <= {div_reg[62:0], 1'b0};
            end
            OP_EMIT:
            begin
                if (act_reg)
                begin
                    out_reg.raw_value     <= '0;
                    out_reg.bounded_value <= '0;
                    out_reg.coin          <= 1'b0;
                    out_reg.state_after   <= seed_reg;
                end
                else
                begin
                    out_reg.raw_value     <= raw_reg;
                    out_reg.bounded_value <= (bound_reg == '0) ? '0 : rem_reg;
                    out_reg.coin          <= raw_reg[0];
                    out_reg.state_after   <= state_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.act = act_reg;
    assign out_data   = out_reg;

    `SMX_ASSERT_NXT(a_draw_coin, cmd.op == OP_EMIT && !act_reg,
        out_reg.coin == out_reg.raw_value[0], "coin differs from raw value lsb")
    `SMX_ASSERT_NXT(a_seed_result, cmd.op == OP_EMIT && act_reg,
        out_reg.raw_value == '0 && out_reg.state_after == state_reg,
        "reseed result does not match loaded state")
    `SMX_ASSERT_IMP(a_rem_range, cmd.op == OP_MOD && bound_reg != '0,
        rem_reg < bound_reg, "partial remainder not below the bound")

endmodule

// ----- src/smx_ctrl.sv -----
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer for the SplitMix64 generator: steps the datapath through the
// mixing rounds and the modulo, and owns the result transfer handshake.
// ----------------------------------------------------------------------------
`include "splitmix64_generator_macros.svh"

module smx_ctrl
    import smx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADV,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MA3,
        ST_XSB,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_MB3,
        ST_FIN,
        ST_MOD,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [MOD_CNT_W-1:0]   cnt_reg;
    logic                   out_valid_reg;
    logic                   emit_go;

    // result register is free when empty or being drained this cycle
    assign emit_go = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.op    = OP_IDLE;
        cmd.mul_b = 1'b0;
        cmd.phase = PH_LL;
        unique case (state_reg)
            ST_IDLE:  cmd.op = in_valid ? OP_CAPTURE : OP_IDLE;
            ST_CHECK: cmd.op = OP_IDLE;
            ST_ADV:   cmd.op = OP_ADV;
            ST_MA0:   begin cmd.op = OP_MUL; cmd.phase = PH_LL;  end
            ST_MA1:   begin cmd.op = OP_MUL; cmd.phase = PH_LH;  end
            ST_MA2:   begin cmd.op = OP_MUL; cmd.phase = PH_HL;  end
            ST_MA3:   begin cmd.op = OP_MUL; cmd.phase = PH_SUM; end
            ST_XSB:   cmd.op = OP_XSB;
            ST_MB0:   begin cmd.op = OP_MUL; cmd.mul_b = 1'b1; cmd.phase = PH_LL;  end
            ST_MB1:   begin cmd.op = OP_MUL; cmd.mul_b = 1'b1; cmd.phase = PH_LH;  end
            ST_MB2:   begin cmd.op = OP_MUL; cmd.mul_b = 1'b1; cmd.phase = PH_HL;  end
            ST_MB3:   begin cmd.op = OP_MUL; cmd.mul_b = 1'b1; cmd.phase = PH_SUM; end
            ST_FIN:   cmd.op = OP_FIN;
            ST_MOD:   cmd.op = OP_MOD;
            ST_EMIT:  cmd.op = emit_go ? OP_EMIT : OP_IDLE;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result takes the register even while the old one drains
            if (state_reg == ST_EMIT && emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: state_reg <= status.act ? ST_EMIT : ST_ADV;
                ST_ADV:   state_reg <= ST_MA0;
                ST_MA0:   state_reg <= ST_MA1;
                ST_MA1:   state_reg <= ST_MA2;
                ST_MA2:   state_reg <= ST_MA3;
                ST_MA3:   state_reg <= ST_XSB;
                ST_XSB:   state_reg <= ST_MB0;
                ST_MB0:   state_reg <= ST_MB1;
                ST_MB1:   state_reg <= ST_MB2;
                ST_MB2:   state_reg <= ST_MB3;
                ST_MB3:   state_reg <= ST_FIN;
                ST_FIN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MOD;
                end
                ST_MOD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // hold until the result register can take the transfer
                    if (emit_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `SMX_ASSERT_NXT(a_accept_check, in_valid && state_reg == ST_IDLE,
        state_reg == ST_CHECK, "accepted item did not start the sequence")
    `SMX_ASSERT_NXT(a_mod_end, state_reg == ST_MOD && cnt_reg == MOD_CNT_W'(MOD_STEPS - 1),
        state_reg == ST_EMIT, "modulo did not end after the last step")
    `SMX_ASSERT_NXT(a_emit_valid, state_reg == ST_EMIT && emit_go,
        out_valid_reg && state_reg == ST_IDLE, "emitted result not presented")

endmodule

// ----- src/splitmix64_generator.sv -----
// A draw runs from the input transfer to out_valid; a new item can be taken in
// the cycle in which out_valid rises. A draw's length is set by the 64-step
// restoring modulo and the multiply passes through the shared 32x32 multiplier.
// A reseed goes from the capture and check steps straight to the emit step.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) clears the generator state to zero.
// ----------------------------------------------------------------------------
// splitmix64_generator
// SplitMix64 pseudo-random generator with bounded draw and coin output.
// ----------------------------------------------------------------------------
module splitmix64_generator
    import smx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t    cmd;
    status_t status;

    smx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    smx_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

endmodule
